// ----- hw/rtl/pce_sobol_pkg.sv -----
// Shared types, constants and helpers of the Sobol index accumulator.
package pce_sobol_pkg;

  localparam int DIMS_DEF        = 4;
  localparam int DEGREE_BITS_DEF = 8;

  localparam int COEF_W  = 32;
  localparam int DEG_W   = 32;
  localparam int VAL_W   = 64;
  localparam int SEL_W   = 4;
  localparam int KIND_W  = 2;
  localparam int FLOOR_W = 32;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam int Q_BITS  = 31;
  localparam int DCNT_W  = $clog2(Q_BITS + 1);

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(3);
  localparam logic [VAL_W-1:0]   ONE_Q31     = VAL_W'(1) << Q_BITS;

  localparam logic [KIND_W-1:0] KIND_COMPONENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TOTAL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VARIANCE  = 2'd2;

  localparam logic REG_NORMALIZE = 1'b0;
  localparam logic REG_FLOOR     = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WAIT,
    ST_READ,
    ST_LOAD,
    ST_PICK,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_t;

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? '1 : s[VAL_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/pce_sobol_index_accumulator_unit.sv -----
// Sobol index accumulator: bins squared expansion coefficients and emits indices.
//
// Terms enter on start/busy: a term is taken at a clock edge with start high
// and busy low. Terms may follow back to back. The squared coefficient is
// added to the bin memory by a read-modify-write, with forwarding when
// consecutive terms hit the same bin. A term with last_term set is added
// first, then busy stays high while the run is emitted: 2^DIMS-1 component
// beats, DIMS total beats, one variance beat marked by last_result. Each
// result stands on the result ports for one cycle under result_valid; the
// receiver cannot stall it. Without normalization a component beat passes
// through READ, LOAD and EMIT and a total or variance beat through PICK and
// EMIT; with normalization each component and total beat adds a CHECK state
// and, for a value below the variance, DIV states (one quotient bit per
// cycle). The bins are cleared as they are read. After reset the block sweeps
// the bin memory to zero with busy high; the APB port is live throughout.
module pce_sobol_index_accumulator_unit #(
  parameter int DIMS        = pce_sobol_pkg::DIMS_DEF,
  parameter int DEGREE_BITS = pce_sobol_pkg::DEGREE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [pce_sobol_pkg::COEF_W-1:0] coefficient,
  input  logic [pce_sobol_pkg::DEG_W-1:0]    degrees,
  input  logic                               last_term,
  output logic                               result_valid,
  output logic [pce_sobol_pkg::KIND_W-1:0]   result_kind,
  output logic [pce_sobol_pkg::SEL_W-1:0]    result_selector,
  output logic [pce_sobol_pkg::VAL_W-1:0]    result_value,
  output logic                               last_result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pce_sobol_pkg::APB_AW-1:0]   paddr,
  input  logic [pce_sobol_pkg::APB_DW-1:0]   pwdata,
  output logic [pce_sobol_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  import pce_sobol_pkg::*;

  localparam int NUM_BINS    = (1 << DIMS) - 1;
  localparam int NUM_RESULTS = NUM_BINS + DIMS + 1;
  localparam int CNT_W       = $clog2(NUM_RESULTS + 1);
  localparam logic [CNT_W-1:0] BINS_C    = CNT_W'(NUM_BINS);
  localparam logic [CNT_W-1:0] LAST_BIN  = CNT_W'(NUM_BINS - 1);
  localparam logic [CNT_W-1:0] VAR_IDX   = CNT_W'(NUM_BINS + DIMS);

  state_t state, state_next;

  logic              normalize_enable;
  logic [FLOOR_W-1:0] variance_floor;
  logic              cfg_write;

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic              is_comp;
  logic              is_var;
  logic              norm;
  logic              accept;

  logic [COEF_W-1:0] coef_u;
  logic [COEF_W-1:0] mag;
  logic [VAL_W-1:0]  sq_next;
  logic [2*DEG_W-1:0] deg_ext;
  logic [DIMS-1:0]   term_mask;

  logic              p_valid;
  logic [DIMS-1:0]   p_mask;
  logic [VAL_W-1:0]  p_sq;
  logic              fwd_hit;
  logic [VAL_W-1:0]  fwd_data;
  logic [VAL_W-1:0]  acc_base;
  logic [VAL_W-1:0]  acc_sum;

  logic              ram_we;
  logic [DIMS-1:0]   ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [DIMS-1:0]   ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;
  logic              emit_read;
  logic              zero_write;

  logic [VAL_W-1:0]  variance;
  logic [VAL_W-1:0]  tot [DIMS];
  logic [DIMS-1:0]   bin_mask;

  logic [VAL_W-1:0]  val;
  logic [VAL_W-1:0]  rem;
  logic [VAL_W-1:0]  rem_sh;
  logic [VAL_W-1:0]  rem_next;
  logic              take;
  logic [Q_BITS-1:0] quo;
  logic [Q_BITS-1:0] quo_next;
  logic [DCNT_W-1:0] dcnt;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_FLOOR) ? variance_floor
                                             : {{(APB_DW-1){1'b0}}, normalize_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      normalize_enable <= 1'b0;
      variance_floor   <= FLOOR_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_NORMALIZE) begin
        normalize_enable <= pwdata[0];
      end else begin
        variance_floor <= pwdata;
      end
    end
  end

  // term front end
  assign accept  = start && !busy;
  assign coef_u  = coefficient;
  assign mag     = coef_u[COEF_W-1] ? (COEF_W'(0) - coef_u) : coef_u;
  assign sq_next = {{(VAL_W-COEF_W){1'b0}}, mag} * {{(VAL_W-COEF_W){1'b0}}, mag};
  assign deg_ext = {{DEG_W{1'b0}}, degrees};

  always_comb begin
    term_mask = '0;
    for (int d = 0; d < DIMS; d++) begin
      term_mask[d] = |deg_ext[d*DEGREE_BITS +: DEGREE_BITS];
    end
  end

  assign acc_base = fwd_hit ? fwd_data : ram_rdata;
  assign acc_sum  = sat_add(acc_base, p_sq);

  // emission bookkeeping
  assign cnt_inc  = cnt + CNT_W'(1);
  assign is_comp  = cnt < BINS_C;
  assign is_var   = cnt == VAR_IDX;
  assign norm     = normalize_enable && (variance > {{(VAL_W-FLOOR_W){1'b0}}, variance_floor});
  assign bin_mask = cnt[DIMS-1:0] + DIMS'(1);

  // bin memory ports
  assign ram_raddr = emit_read ? cnt[DIMS-1:0] : term_mask - DIMS'(1);
  assign ram_we    = p_valid || zero_write;
  assign ram_waddr = p_valid ? p_mask - DIMS'(1) : cnt[DIMS-1:0];
  assign ram_wdata = p_valid ? acc_sum : '0;

  pce_sobol_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // divider step
  assign rem_sh   = {rem[VAL_W-2:0], 1'b0};
  assign take     = rem[VAL_W-1] || (rem_sh >= variance);
  assign rem_next = take ? rem_sh - variance : rem_sh;
  assign quo_next = {quo[Q_BITS-2:0], take};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (cnt == LAST_BIN) state_next = ST_IDLE;
      ST_IDLE:  if (accept && last_term) state_next = ST_WAIT;
      ST_WAIT:  state_next = ST_READ;
      ST_READ:  state_next = ST_LOAD;
      ST_LOAD:  state_next = norm ? ST_CHECK : ST_EMIT;
      ST_PICK:  state_next = (norm && !is_var) ? ST_CHECK : ST_EMIT;
      ST_CHECK: state_next = (val >= variance) ? ST_EMIT : ST_DIV;
      ST_DIV:   if (dcnt == DCNT_W'(1)) state_next = ST_EMIT;
      ST_EMIT: begin
        priority if (is_var) begin
          state_next = ST_IDLE;
        end else if (cnt_inc < BINS_C) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_PICK;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy         = 1'b1;
    result_valid = 1'b0;
    emit_read    = 1'b0;
    zero_write   = 1'b0;
    unique case (state)
      ST_IDLE:  busy = 1'b0;
      ST_CLEAR: zero_write = 1'b1;
      ST_READ:  emit_read = 1'b1;
      ST_LOAD:  zero_write = 1'b1;
      ST_EMIT:  result_valid = 1'b1;
      ST_WAIT, ST_PICK, ST_CHECK, ST_DIV: ;
      default:  busy = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      p_valid  <= 1'b0;
      fwd_hit  <= 1'b0;
      variance <= '0;
      dcnt     <= '0;
      for (int d = 0; d < DIMS; d++) tot[d] <= '0;
    end else begin
      state   <= state_next;
      p_valid <= accept && (term_mask != '0);
      fwd_hit <= accept && p_valid && (p_mask == term_mask);
      if (p_valid) begin
        variance <= sat_add(variance, p_sq);
      end
      unique case (state)
        ST_CLEAR: cnt <= (cnt == LAST_BIN) ? '0 : cnt_inc;
        ST_LOAD: begin
          for (int d = 0; d < DIMS; d++) begin
            if (bin_mask[d]) tot[d] <= sat_add(tot[d], ram_rdata);
          end
        end
        ST_CHECK: dcnt <= DCNT_W'(Q_BITS);
        ST_DIV:   dcnt <= dcnt - DCNT_W'(1);
        ST_EMIT: begin
          if (is_var) begin
            cnt      <= '0;
            variance <= '0;
          end else begin
            cnt <= cnt_inc;
          end
          if (!is_comp && !is_var) begin
            for (int d = 0; d < DIMS - 1; d++) tot[d] <= tot[d+1];
            tot[DIMS-1] <= '0;
          end
        end
        ST_IDLE, ST_WAIT, ST_READ, ST_PICK: ;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_mask   <= term_mask;
    p_sq     <= sq_next;
    fwd_data <= acc_sum;
    unique case (state)
      ST_LOAD: val <= ram_rdata;
      ST_PICK: val <= is_var ? variance : tot[0];
      ST_CHECK: begin
        if (val >= variance) val <= ONE_Q31;
        rem <= val;
        quo <= '0;
      end
      ST_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        if (dcnt == DCNT_W'(1)) val <= VAL_W'(quo_next);
      end
      ST_CLEAR, ST_IDLE, ST_WAIT, ST_READ, ST_EMIT: ;
      default: ;
    endcase
  end

  // result ports
  assign result_value = val;
  assign last_result  = result_valid && is_var;

  always_comb begin
    priority if (is_comp) begin
      result_kind     = KIND_COMPONENT;
      result_selector = SEL_W'(cnt_inc);
    end else if (is_var) begin
      result_kind     = KIND_VARIANCE;
      result_selector = '0;
    end else begin
      result_kind     = KIND_TOTAL;
      result_selector = SEL_W'(cnt - BINS_C);
    end
  end

  a_emit_only_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result beat while idle");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    last_result |=> !busy)
    else $error("block not idle after final beat");

  a_last_is_variance: assert property (@(posedge clk) disable iff (rst)
    last_result |-> (result_kind == KIND_VARIANCE))
    else $error("final beat is not the variance");

  a_last_term_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && last_term) |=> busy)
    else $error("final term did not start a run");

  a_ratio_bound: assert property (@(posedge clk) disable iff (rst)
    (result_valid && norm && (result_kind != KIND_VARIANCE)) |-> (result_value <= ONE_Q31))
    else $error("normalized ratio above one");

  a_no_emit_during_term: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> !zero_write)
    else $error("term write collides with bin clear");

endmodule

// ----- hw/rtl/pce_sobol_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pce_sobol_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 15,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
